[hw/rtl/lsm_pkg.sv]
`default_nettype none

package lsm_pkg;

  // Width of every timestamp field.
  localparam int StampW = 32;

  // Width of the event code on the input.
  localparam int ActionW = 3;

  // Link states as reported on link_state.
  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_UP      = 3'd1,
    ST_DOWN    = 3'd2,
    ST_FAILED  = 3'd3,
    ST_MISSING = 3'd4,
    ST_NOIF    = 3'd5
  } lsm_state_t;

  // Health event codes carried on action.
  typedef enum logic [ActionW-1:0] {
    EV_PRESENT = 3'd0,
    EV_NETUP   = 3'd1,
    EV_NETDOWN = 3'd2,
    EV_MISSING = 3'd3,
    EV_DEVFAIL = 3'd4,
    EV_NODEV   = 3'd5,
    EV_TIMEOUT = 3'd6
  } lsm_event_t;

  // Link state together with its three timestamps.
  typedef struct packed {
    lsm_state_t         state;
    logic [StampW-1:0]  dev_down;
    logic [StampW-1:0]  net_down;
    logic [StampW-1:0]  chg_time;
  } lsm_ctx_t;

  // What one event produces: the context after it and the change flag.
  typedef struct packed {
    lsm_ctx_t ctx;
    logic     changed;
  } lsm_result_t;

endpackage

`default_nettype wire

[hw/rtl/link_status_monitor_fsm.sv]
// A word moves from the input register to the result register; the registers decouple the sides.
// Throughput: one event word per cycle while the output is not stalled.
// The transition table sits between the input register and the result register.
// Reset (synchronous, active high) returns the link to the start state,
// clears all three timestamps and empties both register stages.
`default_nettype none

module link_status_monitor_fsm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lsm_pkg::ActionW-1:0]   action,
  input  logic [lsm_pkg::StampW-1:0]    time_now,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    link_state,
  output logic                          state_changed,
  output logic [lsm_pkg::StampW-1:0]    device_down_stamp,
  output logic [lsm_pkg::StampW-1:0]    net_down_stamp,
  output logic [lsm_pkg::StampW-1:0]    change_stamp
);

  logic                          in_full;
  logic [lsm_pkg::ActionW-1:0]   in_action;
  logic [lsm_pkg::StampW-1:0]    in_time;
  logic                          step;
  lsm_pkg::lsm_result_t          result;
  lsm_pkg::lsm_result_t          out_word;

  // A held word moves on when the output register is free or draining.
  assign step     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_action <= action;
      in_time   <= time_now;
    end
  end

  lsm_track u_track (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .action   (in_action),
    .time_now (in_time),
    .result   (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= result;
    end
  end

  assign link_state        = out_word.ctx.state;
  assign state_changed     = out_word.changed;
  assign device_down_stamp = out_word.ctx.dev_down;
  assign net_down_stamp    = out_word.ctx.net_down;
  assign change_stamp      = out_word.ctx.chg_time;

endmodule

`default_nettype wire

[hw/rtl/lsm_next.sv]
`default_nettype none

module lsm_next (
  input  lsm_pkg::lsm_ctx_t             ctx,
  input  logic [lsm_pkg::ActionW-1:0]   action,
  input  logic [lsm_pkg::StampW-1:0]    time_now,
  output lsm_pkg::lsm_result_t          result
);

  lsm_pkg::lsm_ctx_t nxt;

  // Transition table with its timestamp side effects.
  always_comb begin
    nxt = ctx;
    case (ctx.state)
      lsm_pkg::ST_START: begin
        if (action inside {lsm_pkg::EV_PRESENT, lsm_pkg::EV_NETDOWN}) begin
          nxt.state = lsm_pkg::ST_DOWN;
        end else if (action == lsm_pkg::EV_NETUP) begin
          nxt.state = lsm_pkg::ST_UP;
        end else if (action == lsm_pkg::EV_MISSING) begin
          nxt.state = lsm_pkg::ST_MISSING;
        end else if (action inside {lsm_pkg::EV_DEVFAIL, lsm_pkg::EV_NODEV}) begin
          nxt.state = lsm_pkg::ST_NOIF;
        end
      end
      lsm_pkg::ST_UP: begin
        if (action == lsm_pkg::EV_NETDOWN) begin
          nxt.state    = lsm_pkg::ST_DOWN;
          nxt.net_down = time_now;
        end else if (action == lsm_pkg::EV_MISSING) begin
          nxt.state    = lsm_pkg::ST_MISSING;
          nxt.dev_down = time_now;
        end else if (action inside {lsm_pkg::EV_DEVFAIL, lsm_pkg::EV_NODEV}) begin
          nxt.state    = lsm_pkg::ST_NOIF;
          nxt.dev_down = time_now;
        end
      end
      lsm_pkg::ST_DOWN: begin
        if (action == lsm_pkg::EV_NETUP) begin
          nxt.state    = lsm_pkg::ST_UP;
          nxt.net_down = '0;
        end else if (action == lsm_pkg::EV_MISSING) begin
          nxt.state    = lsm_pkg::ST_MISSING;
          nxt.dev_down = time_now;
        end else if (action inside {lsm_pkg::EV_DEVFAIL, lsm_pkg::EV_NODEV}) begin
          nxt.state    = lsm_pkg::ST_NOIF;
          nxt.dev_down = time_now;
        end else if (action == lsm_pkg::EV_TIMEOUT) begin
          nxt.state    = lsm_pkg::ST_FAILED;
          nxt.dev_down = time_now;
        end
      end
      lsm_pkg::ST_MISSING: begin
        if (action inside {lsm_pkg::EV_PRESENT, lsm_pkg::EV_NETUP}) begin
          nxt.state    = lsm_pkg::ST_UP;
          nxt.dev_down = '0;
          nxt.net_down = '0;
        end else if (action == lsm_pkg::EV_NETDOWN) begin
          if (ctx.net_down == '0) nxt.net_down = time_now;
        end else if (action inside {lsm_pkg::EV_DEVFAIL, lsm_pkg::EV_MISSING}) begin
          if (ctx.dev_down == '0) nxt.dev_down = time_now;
        end else if (action == lsm_pkg::EV_NODEV) begin
          nxt.state = lsm_pkg::ST_NOIF;
        end else if (action == lsm_pkg::EV_TIMEOUT) begin
          nxt.state = lsm_pkg::ST_FAILED;
        end
      end
      lsm_pkg::ST_NOIF: begin
        if (action == lsm_pkg::EV_NETDOWN) begin
          nxt.state = lsm_pkg::ST_DOWN;
          if (ctx.net_down == '0) nxt.net_down = time_now;
        end else if (action inside {lsm_pkg::EV_PRESENT, lsm_pkg::EV_NETUP}) begin
          nxt.state = lsm_pkg::ST_UP;
        end else if (action == lsm_pkg::EV_MISSING) begin
          nxt.state = lsm_pkg::ST_MISSING;
          if (ctx.dev_down == '0) nxt.dev_down = time_now;
        end else if (action inside {lsm_pkg::EV_DEVFAIL, lsm_pkg::EV_NODEV}) begin
          if (ctx.dev_down == '0) nxt.dev_down = time_now;
        end
      end
      // The failed state is sticky; other codes cannot occur.
      default: begin
        nxt = ctx;
      end
    endcase
  end

  // Stamp the change time whenever the state moves.
  always_comb begin
    result.changed = (nxt.state != ctx.state);
    result.ctx     = nxt;
    if (result.changed) begin
      result.ctx.chg_time = time_now;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lsm_track.sv]
`default_nettype none

module lsm_track (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [lsm_pkg::ActionW-1:0]   action,
  input  logic [lsm_pkg::StampW-1:0]    time_now,
  output lsm_pkg::lsm_result_t          result
);

  lsm_pkg::lsm_ctx_t ctx;

  lsm_next u_next (
    .ctx      (ctx),
    .action   (action),
    .time_now (time_now),
    .result   (result)
  );

  // Link state and timestamps advance once per processed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state    <= lsm_pkg::ST_START;
      ctx.dev_down <= '0;
      ctx.net_down <= '0;
      ctx.chg_time <= '0;
    end else if (step) begin
      ctx <= result.ctx;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lsm_checker.sv]
`default_nettype none

module lsm_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [2:0]                    link_state,
  input  logic                          state_changed,
  input  logic [lsm_pkg::StampW-1:0]    device_down_stamp,
  input  logic [lsm_pkg::StampW-1:0]    net_down_stamp,
  input  logic [lsm_pkg::StampW-1:0]    change_stamp
);

  logic failed_seen;

  // Remember that a failed state has been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      failed_seen <= 1'b0;
    end else if (out_valid && !out_stall && (link_state == lsm_pkg::ST_FAILED)) begin
      failed_seen <= 1'b1;
    end
  end

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  // A stalled output word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(link_state) && $stable(change_stamp))
    else $error("stalled output word changed");

  // Failed is sticky and never announced again.
  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed_seen |-> (link_state == lsm_pkg::ST_FAILED) && !state_changed)
    else $error("left the failed state");

  // The start state is only ever seen before any change, with clear stamps.
  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (link_state == lsm_pkg::ST_START) |->
      !state_changed && (change_stamp == '0) && (device_down_stamp == '0) &&
      (net_down_stamp == '0))
    else $error("start state with a change or a timestamp set");

endmodule

bind link_status_monitor_fsm lsm_checker u_lsm_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .link_state        (link_state),
  .state_changed     (state_changed),
  .device_down_stamp (device_down_stamp),
  .net_down_stamp    (net_down_stamp),
  .change_stamp      (change_stamp)
);

`default_nettype wire
